/* design/ssg_pkg.sv */
package ssg_pkg;

  localparam int PHASE_BITS    = 32;
  localparam int FRAC_BITS     = 16;
  localparam int CORDIC_STAGES = 30;
  localparam int WORK_FRAC     = 30;

  localparam int IDX_W   = 31;
  localparam int LEVEL_W = 17;
  localparam int CFG_W   = 32;
  localparam int ANG_W   = 32;
  localparam int XY_W    = 32;
  localparam int SHIFT_W = $clog2(CORDIC_STAGES);
  localparam int S_W     = FRAC_BITS + 2;
  localparam int SUM_W   = LEVEL_W + 1;
  localparam int NUM_W   = SUM_W + FRAC_BITS + 2;

  localparam logic [LEVEL_W-1:0] LEVEL_ONE = LEVEL_W'(65536);
  localparam logic signed [XY_W-1:0] CORDIC_GAIN = XY_W'(652032874);

  localparam logic signed [ANG_W-1:0] ARC_TABLE [CORDIC_STAGES] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4, 32'h028B0D43,
    32'h0145D7E1, 32'h00A2F61E, 32'h00517C55, 32'h0028BE53, 32'h00145F2F,
    32'h000A2F98, 32'h000517CC, 32'h00028BE6, 32'h000145F3, 32'h0000A2F9,
    32'h0000517C, 32'h000028BE, 32'h0000145F, 32'h00000A2F, 32'h00000517,
    32'h0000028B, 32'h00000145, 32'h000000A2, 32'h00000051, 32'h00000028,
    32'h00000014, 32'h0000000A, 32'h00000005, 32'h00000002, 32'h00000001
  };

  typedef enum logic [1:0] {
    REG_LOW_LEVEL  = 2'd0,
    REG_HIGH_LEVEL = 2'd1,
    REG_PHASE_STEP = 2'd2
  } cfg_reg_t;

  typedef struct packed {
    logic signed [XY_W-1:0]  x;
    logic signed [XY_W-1:0]  y;
    logic signed [ANG_W-1:0] a;
  } cordic_t;

endpackage

/* design/ssg_phase_stage.sv */
module ssg_phase_stage import ssg_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic [IDX_W-1:0]      item_index,
  input  logic [CFG_W-1:0]      phase_step,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output cordic_t               dn_data
);

  logic                      v1_r, v2_r;
  logic [PHASE_BITS-1:0]     phase_r, phase_nxt;
  cordic_t                   data_r, data_nxt;
  logic                      rdy1, rdy2;
  logic [IDX_W+CFG_W-1:0]    prod;
  logic [ANG_W-1:0]          angle;
  logic signed [ANG_W:0]     a_ext, a_fold;

  localparam logic signed [ANG_W:0] QUARTER = (ANG_W+1)'(1) <<< (ANG_W - 2);
  localparam logic signed [ANG_W:0] HALF    = (ANG_W+1)'(1) <<< (ANG_W - 1);

  assign rdy2     = !v2_r || dn_ready;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;
  assign dn_valid = v2_r;
  assign dn_data  = data_r;

  always_comb begin
    prod      = (IDX_W+CFG_W)'(item_index) * (IDX_W+CFG_W)'(phase_step);
    phase_nxt = prod[PHASE_BITS-1:0];
    angle     = ANG_W'(phase_r) << (ANG_W - PHASE_BITS);
    a_ext     = (ANG_W+1)'($signed(angle));
    if (a_ext > QUARTER) begin
      a_fold = HALF - a_ext;
    end else if (a_ext < -QUARTER) begin
      a_fold = -HALF - a_ext;
    end else begin
      a_fold = a_ext;
    end
    data_nxt.x = CORDIC_GAIN;
    data_nxt.y = '0;
    data_nxt.a = a_fold[ANG_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) phase_r <= phase_nxt;
    if (rdy2) data_r <= data_nxt;
  end

endmodule

/* design/ssg_cordic_cell.sv */
module ssg_cordic_cell import ssg_pkg::*; (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic [SHIFT_W-1:0]       shift,
  input  logic signed [ANG_W-1:0]  arc,
  input  logic                     up_valid,
  output logic                     up_ready,
  input  cordic_t                  up_data,
  output logic                     dn_valid,
  input  logic                     dn_ready,
  output cordic_t                  dn_data
);

  logic                    valid_r;
  cordic_t                 data_r, data_nxt;
  logic signed [XY_W-1:0]  dx, dy;

  assign up_ready = !valid_r || dn_ready;
  assign dn_valid = valid_r;
  assign dn_data  = data_r;

  always_comb begin
    dx = up_data.y >>> shift;
    dy = up_data.x >>> shift;
    if (!up_data.a[ANG_W-1]) begin
      data_nxt.x = up_data.x - dx;
      data_nxt.y = up_data.y + dy;
      data_nxt.a = up_data.a - arc;
    end else begin
      data_nxt.x = up_data.x + dx;
      data_nxt.y = up_data.y - dy;
      data_nxt.a = up_data.a + arc;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (up_ready) begin
      valid_r <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) data_r <= data_nxt;
  end

endmodule

/* design/ssg_level_stage.sv */
module ssg_level_stage import ssg_pkg::*; (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    up_valid,
  output logic                    up_ready,
  input  logic signed [XY_W-1:0]  y_in,
  input  logic [SUM_W-1:0]        level_sum,
  input  logic [LEVEL_W-1:0]      level_diff,
  output logic                    dn_valid,
  input  logic                    dn_ready,
  output logic [LEVEL_W-1:0]      level
);

  localparam int RND_SHIFT = WORK_FRAC - FRAC_BITS;
  localparam logic signed [XY_W:0] Y_RND = (XY_W+1)'(1) <<< (RND_SHIFT - 1);
  localparam logic signed [XY_W:0] S_LIM = (XY_W+1)'(1) <<< FRAC_BITS;
  localparam logic signed [NUM_W-1:0] FRAC_ONE = NUM_W'(1) <<< FRAC_BITS;

  logic                        v1_r, v2_r;
  logic signed [S_W-1:0]       s_r, s_nxt;
  logic [LEVEL_W-1:0]          level_r, level_nxt;
  logic                        rdy1, rdy2;
  logic signed [XY_W:0]        y_rnd;
  logic signed [LEVEL_W:0]     diff_s;
  logic signed [NUM_W-1:0]     prod, base, num, quot;

  assign rdy2     = !v2_r || dn_ready;
  assign rdy1     = !v1_r || rdy2;
  assign up_ready = rdy1;
  assign dn_valid = v2_r;
  assign level    = level_r;

  always_comb begin
    y_rnd = ((XY_W+1)'(y_in) + Y_RND) >>> RND_SHIFT;
    if (y_rnd > S_LIM) begin
      s_nxt = S_W'(S_LIM);
    end else if (y_rnd < -S_LIM) begin
      s_nxt = S_W'(-S_LIM);
    end else begin
      s_nxt = S_W'(y_rnd);
    end
  end

  always_comb begin
    diff_s = $signed({1'b0, level_diff});
    prod   = diff_s * s_r;
    base   = $signed(NUM_W'({level_sum, {FRAC_BITS{1'b0}}}));
    num    = base + prod + FRAC_ONE;
    quot   = num >>> (FRAC_BITS + 1);
    if (num[NUM_W-1]) begin
      level_nxt = '0;
    end else if (quot > NUM_W'(LEVEL_ONE)) begin
      level_nxt = LEVEL_ONE;
    end else begin
      level_nxt = quot[LEVEL_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= up_valid;
      if (rdy2) v2_r <= v1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rdy1) s_r <= s_nxt;
    if (rdy2) level_r <= level_nxt;
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    v1_r |-> (s_r <= S_W'(S_LIM)) && (s_r >= S_W'(-S_LIM)))
    else $error("sine sample out of range");

  assert property (@(posedge clk) disable iff (!rst_n)
    v2_r |-> level_r <= LEVEL_ONE)
    else $error("level above one");

  assert property (@(posedge clk)
    !rst_n |=> !v1_r && !v2_r)
    else $error("valid not cleared by reset");

endmodule

/* design/sine_schedule_generator_top.sv */
// Channel | Direction | Handshake             | Payload
// in      | input     | in_valid / in_stall   | in_item_index[30:0]
// out     | output    | out_valid / out_stall | out_level[16:0]
// cfg     | input     | cfg_valid / cfg_ready | cfg_index[1:0], cfg_data[31:0]
//
// One beat per cycle in each direction while out_stall is low; two phase stages,
// thirty CORDIC cells, two level stages.
// Synchronous active-low reset empties the pipeline and loads the register defaults.
// Each stage holds its beat while the next one is full and stalled; a bubble is
// filled even when the output is stalled.
module sine_schedule_generator_top import ssg_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  logic [IDX_W-1:0]    in_item_index,
  output logic                out_valid,
  input  logic                out_stall,
  output logic [LEVEL_W-1:0]  out_level,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [CFG_W-1:0]    cfg_data
);

  logic [LEVEL_W-1:0] low_level_r, high_level_r;
  logic [CFG_W-1:0]   phase_step_r;
  logic [LEVEL_W-1:0] lo_eff, hi_eff;
  logic [SUM_W-1:0]   level_sum;
  logic [LEVEL_W-1:0] level_diff;

  logic               in_ready;
  logic               cell_valid [CORDIC_STAGES+1];
  logic               cell_ready [CORDIC_STAGES+1];
  cordic_t            cell_data  [CORDIC_STAGES+1];

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      low_level_r  <= '0;
      high_level_r <= LEVEL_ONE;
      phase_step_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_reg_t'(cfg_index))
        REG_LOW_LEVEL:  low_level_r  <= cfg_data[LEVEL_W-1:0];
        REG_HIGH_LEVEL: high_level_r <= cfg_data[LEVEL_W-1:0];
        REG_PHASE_STEP: phase_step_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // swap reversed bounds
  always_comb begin
    if (low_level_r > high_level_r) begin
      lo_eff = high_level_r;
      hi_eff = low_level_r;
    end else begin
      lo_eff = low_level_r;
      hi_eff = high_level_r;
    end
    level_sum  = SUM_W'(lo_eff) + SUM_W'(hi_eff);
    level_diff = hi_eff - lo_eff;
  end

  assign in_stall = !in_ready;

  ssg_phase_stage u_phase (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (in_valid),
    .up_ready   (in_ready),
    .item_index (in_item_index),
    .phase_step (phase_step_r),
    .dn_valid   (cell_valid[0]),
    .dn_ready   (cell_ready[0]),
    .dn_data    (cell_data[0])
  );

  for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cell
    ssg_cordic_cell u_cell (
      .clk      (clk),
      .rst_n    (rst_n),
      .shift    (SHIFT_W'(i)),
      .arc      (ARC_TABLE[i]),
      .up_valid (cell_valid[i]),
      .up_ready (cell_ready[i]),
      .up_data  (cell_data[i]),
      .dn_valid (cell_valid[i+1]),
      .dn_ready (cell_ready[i+1]),
      .dn_data  (cell_data[i+1])
    );
  end

  ssg_level_stage u_level (
    .clk        (clk),
    .rst_n      (rst_n),
    .up_valid   (cell_valid[CORDIC_STAGES]),
    .up_ready   (cell_ready[CORDIC_STAGES]),
    .y_in       (cell_data[CORDIC_STAGES].y),
    .level_sum  (level_sum),
    .level_diff (level_diff),
    .dn_valid   (out_valid),
    .dn_ready   (!out_stall),
    .level      (out_level)
  );

endmodule
